[hdl/hsl_pkg.sv]
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants and types for the HSL to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

  // Input limits and hue geometry, in whole degrees and whole percent
  localparam int unsigned HUE_TURN  = 360;
  localparam int unsigned HUE_THIRD = HUE_TURN / 3;
  localparam int unsigned SIXTH     = HUE_TURN / 6;
  localparam int unsigned PCT_FULL  = 100;
  localparam int unsigned CHAN_MAX  = 255;

  // Field widths
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CHAN_W = 8;

  // p, q and q - p in units of 1/10000 (at most 10000)
  localparam int unsigned PQ_W  = 14;
  // Channel numerator over 10000 * 60 (at most 600000)
  localparam int unsigned NUM_W = 20;

  // Byte scaling: v = (num * 510 + 600000) / 1200000
  //             = (num * 17 + 20000) / 40000
  //             = ((num * 17 + 20000) >> 6) / 625
  localparam int unsigned SCALE_MUL   = 17;
  localparam int unsigned ROUND_BIAS  = 20000;
  localparam int unsigned SCALED_W    = 24;
  localparam int unsigned PRE_SHIFT   = 6;
  localparam int unsigned QUOT_IN_W   = SCALED_W - PRE_SHIFT;
  // Reciprocal of 625 scaled by 2^28, rounded up; exact for 18-bit dividends
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_MUL   = 429497;
  localparam int unsigned RECIP_W     = 37;

  // Word handed from the front stage to one channel lane
  typedef struct packed {
    logic [PQ_W-1:0]  p;
    logic [PQ_W-1:0]  diff;
    logic [HUE_W-1:0] hue_pos;
  } hsl_lane_t;

endpackage

[hdl/hsl_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to 8-bit RGB conversion, one pixel per clock, four register stages.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Word
//   in_       input      start / busy        hue_deg, sat_pct, light_pct
//   out_      output     out_valid strobe    red, green, blue, range_error
//
// A word is taken on every clock edge with start high; busy stays low.
// The front stage loads on the accepting edge, then two lane stages and the
// output register follow; out_valid is driven from that output register.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall, so the pipeline advances on every cycle.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hsl_pkg::HUE_W-1:0]    in_hue_deg,
  input  logic [hsl_pkg::PCT_W-1:0]    in_sat_pct,
  input  logic [hsl_pkg::PCT_W-1:0]    in_light_pct,
  output logic                         out_valid,
  output logic [hsl_pkg::CHAN_W-1:0]   out_red,
  output logic [hsl_pkg::CHAN_W-1:0]   out_green,
  output logic [hsl_pkg::CHAN_W-1:0]   out_blue,
  output logic                         out_range_error
);

  logic                         s1_valid;
  logic                         s1_err;
  hsl_pkg::hsl_lane_t           s1_red;
  hsl_pkg::hsl_lane_t           s1_green;
  hsl_pkg::hsl_lane_t           s1_blue;
  logic                         s2_valid_r;
  logic                         s2_err_r;
  logic                         s3_valid_r;
  logic                         s3_err_r;
  logic [hsl_pkg::CHAN_W-1:0]   red_byte;
  logic [hsl_pkg::CHAN_W-1:0]   green_byte;
  logic [hsl_pkg::CHAN_W-1:0]   blue_byte;
  logic                         out_valid_r;
  logic [hsl_pkg::CHAN_W-1:0]   out_red_r;
  logic [hsl_pkg::CHAN_W-1:0]   out_green_r;
  logic [hsl_pkg::CHAN_W-1:0]   out_blue_r;
  logic                         out_err_r;
  logic [hsl_pkg::CHAN_W-1:0]   red_nxt;
  logic [hsl_pkg::CHAN_W-1:0]   green_nxt;
  logic [hsl_pkg::CHAN_W-1:0]   blue_nxt;

  // Never hold off the sender
  assign busy = 1'b0;

  hsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .hue_deg   (in_hue_deg),
    .sat_pct   (in_sat_pct),
    .light_pct (in_light_pct),
    .valid_r   (s1_valid),
    .err_r     (s1_err),
    .red_r     (s1_red),
    .green_r   (s1_green),
    .blue_r    (s1_blue)
  );

  hsl_lane u_lane_red (
    .clk       (clk),
    .lane_in   (s1_red),
    .chan_byte (red_byte)
  );

  hsl_lane u_lane_green (
    .clk       (clk),
    .lane_in   (s1_green),
    .chan_byte (green_byte)
  );

  hsl_lane u_lane_blue (
    .clk       (clk),
    .lane_in   (s1_blue),
    .chan_byte (blue_byte)
  );

  // Drop the channels to zero on a range error
  always_comb begin
    if (s3_err_r) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      red_nxt   = red_byte;
      green_nxt = green_byte;
      blue_nxt  = blue_byte;
    end
  end

  // Advance valid bits alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s1_valid;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Carry the error flag and register the result word
  always_ff @(posedge clk) begin
    s2_err_r    <= s1_err;
    s3_err_r    <= s2_err_r;
    out_err_r   <= s3_err_r;
    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_range_error = out_err_r;

endmodule

[hdl/hsl_front.sv]
// ----------------------------------------------------------------------------
// hsl_front
// First pipeline stage: range check, p and q levels, and the hue position
// of each of the three channels.
// ----------------------------------------------------------------------------
module hsl_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [hsl_pkg::HUE_W-1:0]   hue_deg,
  input  logic [hsl_pkg::PCT_W-1:0]   sat_pct,
  input  logic [hsl_pkg::PCT_W-1:0]   light_pct,
  output logic                        valid_r,
  output logic                        err_r,
  output hsl_pkg::hsl_lane_t          red_r,
  output hsl_pkg::hsl_lane_t          green_r,
  output hsl_pkg::hsl_lane_t          blue_r
);

  logic                        err_nxt;
  logic [15:0]                 l100;
  logic [15:0]                 s100;
  logic [15:0]                 ls;
  logic [15:0]                 q;
  logic [15:0]                 p;
  logic [15:0]                 diff;
  logic [hsl_pkg::HUE_W-1:0]   pos_red;
  logic [hsl_pkg::HUE_W-1:0]   pos_blue;
  hsl_pkg::hsl_lane_t          red_nxt;
  hsl_pkg::hsl_lane_t          green_nxt;
  hsl_pkg::hsl_lane_t          blue_nxt;

  // Flag any field outside its valid range
  assign err_nxt = (32'(hue_deg) >= hsl_pkg::HUE_TURN) ||
                   (32'(sat_pct) > hsl_pkg::PCT_FULL) ||
                   (32'(light_pct) > hsl_pkg::PCT_FULL);

  // Levels q and p in units of 1/10000
  always_comb begin
    l100 = 16'(light_pct) * 16'(hsl_pkg::PCT_FULL);
    s100 = 16'(sat_pct) * 16'(hsl_pkg::PCT_FULL);
    ls   = 16'(light_pct) * 16'(sat_pct);
    if ((32'(light_pct) << 1) < hsl_pkg::PCT_FULL) begin
      q = l100 + ls;
    end else begin
      q = l100 + s100 - ls;
    end
    p    = (l100 << 1) - q;
    diff = q - p;
  end

  // Hue positions: red leads by a third of a turn, blue lags by a third
  always_comb begin
    if (32'(hue_deg) > hsl_pkg::HUE_TURN - hsl_pkg::HUE_THIRD) begin
      pos_red = hue_deg - hsl_pkg::HUE_W'(hsl_pkg::HUE_TURN - hsl_pkg::HUE_THIRD);
    end else begin
      pos_red = hue_deg + hsl_pkg::HUE_W'(hsl_pkg::HUE_THIRD);
    end
    if (32'(hue_deg) < hsl_pkg::HUE_THIRD) begin
      pos_blue = hue_deg + hsl_pkg::HUE_W'(hsl_pkg::HUE_TURN - hsl_pkg::HUE_THIRD);
    end else begin
      pos_blue = hue_deg - hsl_pkg::HUE_W'(hsl_pkg::HUE_THIRD);
    end
  end

  // Assemble the lane words
  always_comb begin
    red_nxt.p         = p[hsl_pkg::PQ_W-1:0];
    red_nxt.diff      = diff[hsl_pkg::PQ_W-1:0];
    red_nxt.hue_pos   = pos_red;
    green_nxt.p       = p[hsl_pkg::PQ_W-1:0];
    green_nxt.diff    = diff[hsl_pkg::PQ_W-1:0];
    green_nxt.hue_pos = hue_deg;
    blue_nxt.p        = p[hsl_pkg::PQ_W-1:0];
    blue_nxt.diff     = diff[hsl_pkg::PQ_W-1:0];
    blue_nxt.hue_pos  = pos_blue;
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Capture the stage payload
  always_ff @(posedge clk) begin
    err_r   <= err_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

endmodule

[hdl/hsl_lane.sv]
// ----------------------------------------------------------------------------
// hsl_lane
// One channel lane: piecewise hue weight and product, scaled numerator,
// and reciprocal divide down to a rounded byte.
// ----------------------------------------------------------------------------
module hsl_lane (
  input  logic                          clk,
  input  hsl_pkg::hsl_lane_t            lane_in,
  output logic [hsl_pkg::CHAN_W-1:0]    chan_byte
);

  logic [6:0]                           weight;
  logic [hsl_pkg::NUM_W-1:0]            prod_nxt;
  logic [hsl_pkg::NUM_W-1:0]            base_nxt;
  logic [hsl_pkg::NUM_W-1:0]            prod_r;
  logic [hsl_pkg::NUM_W-1:0]            base_r;
  logic [hsl_pkg::NUM_W-1:0]            num;
  logic [hsl_pkg::SCALED_W-1:0]         scaled;
  logic [hsl_pkg::QUOT_IN_W-1:0]        quot_in_nxt;
  logic [hsl_pkg::QUOT_IN_W-1:0]        quot_in_r;
  logic [hsl_pkg::RECIP_W-1:0]          recip_prod;
  logic [hsl_pkg::RECIP_W-hsl_pkg::RECIP_SHIFT-1:0] quot;

  // Weight of q - p over the hue position: ramp up, flat top, ramp down, floor
  always_comb begin
    if (32'(lane_in.hue_pos) < hsl_pkg::SIXTH) begin
      weight = 7'(lane_in.hue_pos);
    end else if (32'(lane_in.hue_pos) < 3 * hsl_pkg::SIXTH) begin
      weight = 7'(hsl_pkg::SIXTH);
    end else if (32'(lane_in.hue_pos) < 4 * hsl_pkg::SIXTH) begin
      weight = 7'(hsl_pkg::HUE_W'(4 * hsl_pkg::SIXTH) - lane_in.hue_pos);
    end else begin
      weight = 7'd0;
    end
    prod_nxt = hsl_pkg::NUM_W'(lane_in.diff) * hsl_pkg::NUM_W'(weight);
    base_nxt = hsl_pkg::NUM_W'(lane_in.p) * hsl_pkg::NUM_W'(hsl_pkg::SIXTH);
  end

  // Numerator, scaled and biased for rounding, then drop the power-of-two part
  always_comb begin
    num         = base_r + prod_r;
    scaled      = hsl_pkg::SCALED_W'(num) * hsl_pkg::SCALED_W'(hsl_pkg::SCALE_MUL) +
                  hsl_pkg::SCALED_W'(hsl_pkg::ROUND_BIAS);
    quot_in_nxt = scaled[hsl_pkg::SCALED_W-1:hsl_pkg::PRE_SHIFT];
  end

  // Divide by 625 through the reciprocal, clamp to the byte range
  always_comb begin
    recip_prod = hsl_pkg::RECIP_W'(quot_in_r) * hsl_pkg::RECIP_W'(hsl_pkg::RECIP_MUL);
    quot       = recip_prod[hsl_pkg::RECIP_W-1:hsl_pkg::RECIP_SHIFT];
    if (32'(quot) > hsl_pkg::CHAN_MAX) begin
      chan_byte = hsl_pkg::CHAN_W'(hsl_pkg::CHAN_MAX);
    end else begin
      chan_byte = quot[hsl_pkg::CHAN_W-1:0];
    end
  end

  // Advance the lane stages
  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    base_r    <= base_nxt;
    quot_in_r <= quot_in_nxt;
  end

endmodule
